@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define SIPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// trigger implies the consequence on the following edge
`define SIPC_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sipc_pkg.sv @@
package sipc_pkg;

   localparam int NUM_VECTORS_DEF  = 8;
   localparam int TIMER_VECTOR_DEF = 6;

   localparam int OPCODE_W   = 3;
   localparam int VEC_W      = 3;
   localparam int HANDLER_W  = 32;
   localparam int TIMER_W    = 16;
   localparam int REPEAT_W   = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // packed payload widths, rounded up to whole bytes
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_REQUEST = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ARM     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DISARM  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP     = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_TIMER   = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic item_load;
      logic csr_load;
   } cmd_type;

endpackage

@@ hw/rtl/soft_interrupt_priority_controller.sv @@
// software interrupt controller with priority pop and a countdown timer
//
// req channel: one command per transfer; req_tuser carries the opcode,
//   req_tdata the vector index, handler word, timer start and repeat count
// rsp channel: exactly one result per command; rsp_tuser is the found flag,
//   rsp_tdata the handler word and vector of a pop (zero otherwise)
// csr channel: writes the master enable (index 0) or the timer period
//   (index 1); always ready, takes effect on the next cycle
//
// result: registered; it appears in the cycle after its command is accepted
// throughput: one command per cycle while rsp_tready stays high; every opcode, including the priority
//   encode of the pop and the timer step, finishes in one datapath update
// stall: the result sits in an output register until rsp_tready; during
//   that time req_tready follows rsp_tready, so no result is lost
// reset: synchronous, clears masks and timer, enable to 1, period to 0;
//   the clear opcode does the same
module soft_interrupt_priority_controller #(
   parameter int NUM_VECTORS  = sipc_pkg::NUM_VECTORS_DEF,
   parameter int TIMER_VECTOR = sipc_pkg::TIMER_VECTOR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vector_index[2:0], handler_value[34:3], timer_start[50:35],
   // repeat_count[58:51], zero pad
   input  logic [sipc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode[2:0]
   input  logic [sipc_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // handler_out[31:0], vector_out[34:32], zero pad
   output logic [sipc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found[0]
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sipc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sipc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sipc_pkg::*;

   cmd_type              cmd;
   logic                 found;
   logic [HANDLER_W-1:0] handler_out;
   logic [VEC_W-1:0]     vector_out;

   sipc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd)
   );

   sipc_datapath #(
      .NUM_VECTORS  (NUM_VECTORS),
      .TIMER_VECTOR (TIMER_VECTOR)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .opcode        (req_tuser),
      .vector_index  (req_tdata[2:0]),
      .handler_value (req_tdata[34:3]),
      .timer_start   (req_tdata[50:35]),
      .repeat_count  (req_tdata[58:51]),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .found         (found),
      .handler_out   (handler_out),
      .vector_out    (vector_out)
   );

   assign rsp_tdata = {{(RSP_DATA_W - HANDLER_W - VEC_W){1'b0}}, vector_out, handler_out};
   assign rsp_tuser = found;

endmodule

@@ hw/rtl/sipc_ctrl.sv @@
module sipc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_valid,
   output logic              csr_ready,
   output sipc_pkg::cmd_type cmd
);
   import sipc_pkg::*;

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   // a new item may enter while the held result leaves in the same cycle
   assign req_tready = (state_ff == ST_EMPTY) | rsp_tready;
   assign take       = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign cmd.item_load = take;
   assign cmd.csr_load  = csr_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (take) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!take && rsp_tready) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_tvalid = (state_ff == ST_FULL);

endmodule

@@ hw/rtl/sipc_datapath.sv @@
module sipc_datapath #(
   parameter int NUM_VECTORS  = sipc_pkg::NUM_VECTORS_DEF,
   parameter int TIMER_VECTOR = sipc_pkg::TIMER_VECTOR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sipc_pkg::cmd_type                   cmd,
   input  logic [sipc_pkg::OPCODE_W-1:0]       opcode,
   input  logic [sipc_pkg::VEC_W-1:0]          vector_index,
   input  logic [sipc_pkg::HANDLER_W-1:0]      handler_value,
   input  logic [sipc_pkg::TIMER_W-1:0]        timer_start,
   input  logic [sipc_pkg::REPEAT_W-1:0]       repeat_count,
   input  logic [sipc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sipc_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                found,
   output logic [sipc_pkg::HANDLER_W-1:0]      handler_out,
   output logic [sipc_pkg::VEC_W-1:0]          vector_out
);
   import sipc_pkg::*;

   localparam int IDXW = $clog2(NUM_VECTORS);
   localparam logic [NUM_VECTORS-1:0] TIMER_BIT =
      (TIMER_VECTOR < NUM_VECTORS) ? (NUM_VECTORS'(1) << TIMER_VECTOR) : '0;

   logic                   enable_ff, enable_in;
   logic [TIMER_W-1:0]     period_ff, period_in;
   logic [NUM_VECTORS-1:0] armed_ff, armed_in;
   logic [NUM_VECTORS-1:0] pending_ff, pending_in;
   logic [TIMER_W-1:0]     count_ff, count_in;
   logic [REPEAT_W-1:0]    repeats_ff, repeats_in;
   logic                   found_ff, found_in;
   logic [HANDLER_W-1:0]   handler_ff, handler_in;
   logic [VEC_W-1:0]       vector_ff, vector_in;

   // no reset needed: a pop only reads an entry armed since the last clear
   logic [HANDLER_W-1:0]   table_ff [NUM_VECTORS];

   logic [IDXW-1:0]        idx;
   logic [NUM_VECTORS-1:0] vec_mask;
   logic [NUM_VECTORS-1:0] ready_mask;
   logic [IDXW-1:0]        pop_idx;
   logic                   table_wr;
   logic [TIMER_W-1:0]     count_dec;
   logic [REPEAT_W-1:0]    repeats_dec;

   assign idx      = IDXW'(vector_index);
   assign vec_mask = (32'(vector_index) < NUM_VECTORS) ? (NUM_VECTORS'(1) << idx) : '0;
   assign ready_mask  = armed_ff & pending_ff;
   assign count_dec   = count_ff - TIMER_W'(1);
   assign repeats_dec = repeats_ff - REPEAT_W'(1);
   assign table_wr    = cmd.item_load && (opcode == OP_ARM) && (|vec_mask);

   // lowest set bit wins
   always_comb begin
      pop_idx = '0;
      for (int i = NUM_VECTORS - 1; i >= 0; i--) begin
         if (ready_mask[i]) pop_idx = IDXW'(i);
      end
   end

   always_comb begin
      enable_in  = enable_ff;
      period_in  = period_ff;
      armed_in   = armed_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      repeats_in = repeats_ff;
      found_in   = found_ff;
      handler_in = handler_ff;
      vector_in  = vector_ff;

      if (cmd.csr_load) begin
         unique case (csr_index)
            REG_ENABLE: enable_in = csr_data[0];
            REG_PERIOD: period_in = csr_data;
            default:    ;
         endcase
      end

      if (cmd.item_load) begin
         found_in   = 1'b0;
         handler_in = '0;
         vector_in  = '0;
         case (opcode)
            OP_CLEAR: begin
               enable_in  = 1'b1;
               period_in  = '0;
               armed_in   = '0;
               pending_in = '0;
               count_in   = '0;
               repeats_in = '0;
            end
            OP_REQUEST: pending_in = pending_ff | (vec_mask & armed_ff);
            OP_ARM:     armed_in   = armed_ff | vec_mask;
            OP_DISARM:  armed_in   = armed_ff & ~vec_mask;
            OP_POP: begin
               if (enable_ff && (|ready_mask)) begin
                  pending_in          = pending_ff;
                  pending_in[pop_idx] = 1'b0;
                  found_in            = 1'b1;
                  handler_in          = table_ff[pop_idx];
                  vector_in           = VEC_W'(pop_idx);
               end
            end
            OP_TICK: begin
               if (count_ff != '0) begin
                  count_in = count_dec;
                  if (count_dec == '0) begin
                     pending_in = pending_ff | (TIMER_BIT & armed_ff);
                     if (repeats_ff != '0) begin
                        repeats_in = repeats_dec;
                        count_in   = (repeats_dec != '0) ? period_ff : '0;
                     end else begin
                        count_in = period_ff;
                     end
                  end
               end
            end
            OP_TIMER: begin
               count_in   = timer_start;
               repeats_in = repeat_count;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         period_ff  <= '0;
         armed_ff   <= '0;
         pending_ff <= '0;
         count_ff   <= '0;
         repeats_ff <= '0;
      end else begin
         enable_ff  <= enable_in;
         period_ff  <= period_in;
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         repeats_ff <= repeats_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff   <= found_in;
      handler_ff <= handler_in;
      vector_ff  <= vector_in;
      if (table_wr) table_ff[idx] <= handler_value;
   end

   assign found       = found_ff;
   assign handler_out = handler_ff;
   assign vector_out  = vector_ff;

endmodule

@@ hw/rtl/sipc_checker.sv @@
`include "assert_macros.svh"

module sipc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [sipc_pkg::OPCODE_W-1:0]   req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sipc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser
);
   import sipc_pkg::*;

   logic                  req_xfer;
   logic                  other_xfer;
   logic                  rsp_stall;
   logic                  rsp_miss;
   logic [RSP_DATA_W+1:0] rsp_all;

   assign req_xfer   = req_tvalid & req_tready;
   assign other_xfer = req_xfer & (req_tuser != OP_POP);
   assign rsp_stall  = rsp_tvalid & ~rsp_tready;
   assign rsp_miss   = rsp_tvalid & ~rsp_tuser[0];
   assign rsp_all    = {rsp_tvalid, rsp_tuser, rsp_tdata};

   // a held result must not change until it is taken
   `SIPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_all), "held result changed")

   // every accepted command produces a result on the next cycle
   `SIPC_ASSERT_NEXT(a_rsp_follows, clock, reset, req_xfer, rsp_tvalid, "no result after command")

   // only a pop can report a found vector
   `SIPC_ASSERT_NEXT(a_found_pop, clock, reset, other_xfer, !rsp_tuser[0], "found on non-pop")

   // an empty result carries all-zero payload
   `SIPC_ASSERT(a_zero_miss, clock, reset, rsp_miss |-> (rsp_tdata == '0), "payload without found")

   // with no result waiting the block must take commands
   `SIPC_ASSERT(a_ready_empty, clock, reset, !rsp_tvalid |-> req_tready, "not ready while empty")

endmodule

bind soft_interrupt_priority_controller sipc_checker u_sipc_checker (.*);

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sipc_pkg::*;

   localparam int VECTORS         = NUM_VECTORS_DEF;
   localparam int TIMER_VEC       = TIMER_VECTOR_DEF;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic                 found;
      logic [HANDLER_W-1:0] handler;
      logic [VEC_W-1:0]     vector;
   } pop_result_t;

   // predicts the result of every accepted command and checks what comes out
   class irq_scoreboard;
      logic                 master_on;
      logic [TIMER_W-1:0]   reload_value;
      logic [VECTORS-1:0]   armed;
      logic [VECTORS-1:0]   raised;
      logic [HANDLER_W-1:0] handler_word [VECTORS];
      logic [TIMER_W-1:0]   timer_count;
      logic [REPEAT_W-1:0]  expiries_left;
      pop_result_t          predicted_results [$];
      int                   errors;

      function new();
         errors = 0;
         reset_state();
      endfunction

      function void reset_state();
         master_on     = 1'b1;
         reload_value  = '0;
         armed         = '0;
         raised        = '0;
         timer_count   = '0;
         expiries_left = '0;
         for (int i = 0; i < VECTORS; i++) handler_word[i] = '0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_ENABLE) begin
            master_on = value[0];
         end else if (idx == REG_PERIOD) begin
            reload_value = value[TIMER_W-1:0];
         end
      endfunction

      function void latch_request(logic [VEC_W-1:0] vec);
         if (armed[vec]) raised[vec] = 1'b1;
      endfunction

      function void note_command(logic [OPCODE_W-1:0] op, logic [VEC_W-1:0] vec,
                                 logic [HANDLER_W-1:0] handler, logic [TIMER_W-1:0] start,
                                 logic [REPEAT_W-1:0] repeats);
         pop_result_t res;
         res = '0;
         case (op)
            OP_CLEAR: begin
               reset_state();
            end
            OP_REQUEST: begin
               latch_request(vec);
            end
            OP_ARM: begin
               armed[vec]        = 1'b1;
               handler_word[vec] = handler;
            end
            OP_DISARM: begin
               armed[vec] = 1'b0;
            end
            OP_POP: begin
               if (master_on) begin
                  for (int i = 0; i < VECTORS; i++) begin
                     if (armed[i] && raised[i]) begin
                        raised[i]   = 1'b0;
                        res.found   = 1'b1;
                        res.handler = handler_word[i];
                        res.vector  = i[VEC_W-1:0];
                        break;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (timer_count != '0) begin
                  timer_count = timer_count - TIMER_W'(1);
                  if (timer_count == '0) begin
                     latch_request(TIMER_VEC[VEC_W-1:0]);
                     // finite run: reload only while expiries remain
                     if (expiries_left != '0) begin
                        expiries_left = expiries_left - REPEAT_W'(1);
                        if (expiries_left != '0) timer_count = reload_value;
                     end else begin
                        timer_count = reload_value;
                     end
                  end
               end
            end
            OP_TIMER: begin
               timer_count   = start;
               expiries_left = repeats;
            end
            default: begin
            end
         endcase
         predicted_results.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic found, logic [HANDLER_W-1:0] handler, logic [VEC_W-1:0] vector);
         pop_result_t want;
         if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result found=%0b handler=%0h vector=%0d",
                                      found, handler, vector));
         end else begin
            want = predicted_results.pop_front();
            if (found !== want.found)
               report_mismatch($sformatf("found %0b, wanted %0b", found, want.found));
            if (handler !== want.handler)
               report_mismatch($sformatf("handler %0h, wanted %0h", handler, want.handler));
            if (vector !== want.vector)
               report_mismatch($sformatf("vector %0d, wanted %0d", vector, want.vector));
         end
      endtask

      function int outstanding();
         return predicted_results.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OPCODE_W-1:0]   req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   irq_scoreboard sb;
   int            tx_idle_pct      = 0;
   int            rx_stall_pct     = 0;
   bit            hold_off_request = 1'b0;

   soft_interrupt_priority_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // every transfer is seen here with the values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_command(req_tuser, req_tdata[2:0], req_tdata[34:3], req_tdata[50:35],
                            req_tdata[58:51]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[34:32]);
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [VEC_W-1:0] vec,
                               input logic [HANDLER_W-1:0] handler,
                               input logic [TIMER_W-1:0] start,
                               input logic [REPEAT_W-1:0] repeats);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, repeats, start, handler, vec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // enable first, then period, valid held high across both transfers
   task automatic write_registers(input logic [CSR_DATA_W-1:0] enable_word,
                                  input logic [CSR_DATA_W-1:0] period);
      csr_valid <= 1'b1;
      csr_index <= REG_ENABLE;
      csr_data  <= enable_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_PERIOD;
      csr_data  <= period;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic send_random_command();
      int                   pick;
      logic [OPCODE_W-1:0]  op;
      logic [TIMER_W-1:0]   start;
      logic [REPEAT_W-1:0]  repeats;
      pick    = $urandom_range(99);
      start   = TIMER_W'($urandom);
      repeats = REPEAT_W'($urandom);
      if (pick < 3)       op = OP_CLEAR;
      else if (pick < 18) op = OP_ARM;
      else if (pick < 24) op = OP_DISARM;
      else if (pick < 44) op = OP_REQUEST;
      else if (pick < 68) op = OP_POP;
      else if (pick < 88) op = OP_TICK;
      else if (pick < 96) op = OP_TIMER;
      else                op = OP_UNUSED;
      if (op == OP_TIMER) begin
         // mostly short countdowns and few repeats so expiries really happen
         pick = $urandom_range(9);
         if (pick < 8)       start = TIMER_W'($urandom_range(6, 1));
         else if (pick == 8) start = '0;
         if ($urandom_range(9) < 7) repeats = REPEAT_W'($urandom_range(3));
      end
      send_command(op, VEC_W'($urandom), HANDLER_W'($urandom), start, repeats);
   endtask

   task automatic run_directed();
      write_registers(16'h0001, 16'd3);
      send_command(OP_POP, '0, '0, '0, '0);
      send_command(OP_ARM, 3'd0, 32'h0, '0, '0);
      send_command(OP_ARM, 3'd7, 32'hffff_ffff, '0, '0);
      send_command(OP_REQUEST, 3'd7, '0, '0, '0);
      send_command(OP_REQUEST, 3'd0, '0, '0, '0);
      send_command(OP_POP, '0, '0, '0, '0);
      send_command(OP_POP, '0, '0, '0, '0);
      send_command(OP_POP, '0, '0, '0, '0);
      send_command(OP_UNUSED, 3'd7, 32'hffff_ffff, 16'hffff, 8'hff);
      // timer vector not armed yet: expiry dropped, reload still happens
      send_command(OP_TIMER, '0, '0, 16'd2, 8'd2);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_ARM, TIMER_VEC[VEC_W-1:0], 32'ha5a5_5a5a, '0, '0);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_POP, '0, '0, '0, '0);
      send_command(OP_DISARM, 3'd7, '0, '0, '0);
      send_command(OP_REQUEST, 3'd7, '0, '0, '0);
      send_command(OP_POP, '0, '0, '0, '0);
      send_command(OP_TIMER, '0, '0, 16'hffff, 8'hff);
      send_command(OP_TIMER, '0, '0, 16'd1, 8'd0);
      send_command(OP_TICK, '0, '0, '0, '0);
      send_command(OP_CLEAR, 3'd7, 32'hffff_ffff, 16'hffff, 8'hff);
      drain_results();
      // pending bit must survive a pop while disabled
      write_registers(16'hfffe, 16'hffff);
      send_command(OP_ARM, 3'd1, 32'h1234_5678, '0, '0);
      send_command(OP_REQUEST, 3'd1, '0, '0, '0);
      send_command(OP_POP, '0, '0, '0, '0);
      drain_results();
      write_registers(16'h0001, 16'd0);
      send_command(OP_POP, '0, '0, '0, '0);
      drain_results();
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] enable_word;
      logic [CSR_DATA_W-1:0] period;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
            default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
         endcase
         case (p)
            0: period = 16'd2;
            1: period = 16'd0;
            2: period = 16'hffff;
            3: period = 16'd1;
            6: period = 16'hffff;
            default: period = CSR_DATA_W'($urandom_range(5, 1));
         endcase
         if (p == 2 || p == 6)
            enable_word = 16'hfffe;
         else if (p == 5)
            enable_word = 16'hffff;
         else
            enable_word = 16'h0001;
         write_registers(enable_word, period);
         // result side blocks for a while so the block backs up its input
         if (p == 0) hold_off_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_command();
         drain_results();
      end

      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
